@@ rtl/calendar_clock_12_hour_unit_assert.svh @@
// ----------------------------------------------------------------------------
// calendar_clock_12_hour_unit_assert
// Assertion macros for the 12-hour calendar clock.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_12_HOUR_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_12_HOUR_UNIT_ASSERT_SVH

// Check that a condition implies a consequence at the same clock edge.
`define CC12H_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence at the next clock edge.
`define CC12H_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cc12h_pkg.sv @@
// ----------------------------------------------------------------------------
// cc12h_pkg
// Types, constants and calendar helpers for the 12-hour calendar clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc12h_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [3:0]  HOUR_TOP   = 4'd12;
  localparam logic [3:0]  HOUR_PRE   = 4'd11;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;

  // Reset values
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [4:0]  RST_DAY   = 5'd1;
  localparam logic [13:0] RST_YEAR  = 14'd2000;
  localparam logic [3:0]  RST_HOUR  = 4'd12;

  // Reciprocal of 25 scaled by 2^19, exact for any 14-bit year
  localparam int unsigned  RECIP_SHIFT = 19;
  localparam logic [14:0]  RECIP25     = 15'd20972;

  // Date and time as loaded from the input stream
  typedef struct packed {
    logic       pm;
    logic [5:0] second;
    logic [5:0] minute;
    logic [3:0] hour;
    logic [13:0] year;
    logic [4:0] day;
    logic [3:0] month;
  } set_t;

  // Full clock state
  typedef struct packed {
    logic        noon_seen;
    logic        leap;
    logic        pm;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [3:0]  hour;
    logic [13:0] year;
    logic [4:0]  day;
    logic [3:0]  month;
  } clock_t;

  // Gregorian rule: div by 4 and (not div by 25, or div by 16)
  function automatic logic is_leap(input logic [13:0] y);
    logic [28:0] prod;
    logic [9:0]  q;
    logic [13:0] rem25;
    prod  = 29'(y) * 29'(RECIP25);
    q     = prod[28:RECIP_SHIFT];
    rem25 = y - (14'({q, 4'b0000}) + 14'({q, 3'b000}) + 14'(q));
    return (y[1:0] == 2'b00) && ((rem25 != 14'd0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/calendar_clock_12_hour_unit.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_12_hour_unit
// 12-hour real-time clock and calendar with Gregorian leap years.
// ----------------------------------------------------------------------------
//   channel   dir  item
//   s_axis    in   tick or load of date and time (tuser = opcode)
//   m_axis    out  full date and time after each item
//
// One item per cycle sustained while results are taken.
// The input register feeds the carry logic, which writes the clock state;
// the state registers are the result register.
// A stalled result holds the state; one more item waits in the input
// register, and the input side stalls only when both are full.
// Reset sets 1/1/2000 12:00:00 am with no result pending.
`timescale 1ns / 1ps
`include "calendar_clock_12_hour_unit_assert.svh"

module calendar_clock_12_hour_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // set_month[3:0], set_day[8:4], set_year[22:9], set_hour[26:23],
  // set_minute[32:27], set_second[38:33], set_pm[39]
  input  logic [39:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // month[3:0], day[8:4], year[22:9], hour[26:23], minute[32:27],
  // second[38:33], pm[39], leap[40], zero[47:41]
  output logic [47:0] m_axis_tdata
);

  logic              in_valid_q;
  cc12h_pkg::op_e    in_op_q;
  cc12h_pkg::set_t   in_set_q;
  logic              out_valid_q;
  cc12h_pkg::clock_t state_q, state_d;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q  <= cc12h_pkg::op_e'(s_axis_tuser);
      in_set_q <= cc12h_pkg::set_t'(s_axis_tdata);
    end
  end

  cc12h_next u_next (
    .op_i  (in_op_q),
    .set_i (in_set_q),
    .cur_i (state_q),
    .nxt_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q       <= 1'b0;
      state_q.month     <= cc12h_pkg::RST_MONTH;
      state_q.day       <= cc12h_pkg::RST_DAY;
      state_q.year      <= cc12h_pkg::RST_YEAR;
      state_q.hour      <= cc12h_pkg::RST_HOUR;
      state_q.minute    <= 6'd0;
      state_q.second    <= 6'd0;
      state_q.pm        <= 1'b0;
      state_q.leap      <= 1'b1;
      state_q.noon_seen <= 1'b1;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      // drop the valid once taken unless a new item replaces it
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, state_q.leap, state_q.pm, state_q.second, state_q.minute,
                          state_q.hour, state_q.year, state_q.day, state_q.month};

  `CC12H_ASSERT_SAME(a_leap_tracks_year, clk_i, rst_ni, 1'b1,
                     state_q.leap == cc12h_pkg::is_leap(state_q.year),
                     "leap flag out of step with year")
  `CC12H_ASSERT_NEXT(a_pending_held, clk_i, rst_ni, in_valid_q && !advance,
                     in_valid_q && $stable(in_set_q), "pending item lost")
  `CC12H_ASSERT_NEXT(a_state_holds, clk_i, rst_ni, !advance, $stable(state_q),
                     "state moved without an item")
  `CC12H_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, advance, out_valid_q,
                     "item processed without a result")

endmodule

@@ rtl/cc12h_next.sv @@
// ----------------------------------------------------------------------------
// cc12h_next
// Next clock state for one item: a one-second tick with carries, or a load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc12h_next (
  input  cc12h_pkg::op_e    op_i,
  input  cc12h_pkg::set_t   set_i,
  input  cc12h_pkg::clock_t cur_i,
  output cc12h_pkg::clock_t nxt_o
);

  logic [13:0] year_up;
  logic        leap_up;
  logic        day_wrap;

  // Year and leap flag after a year carry, kept off the carry chain
  assign year_up  = (cur_i.year >= cc12h_pkg::YEAR_LAST) ? 14'd0 : cur_i.year + 14'd1;
  assign leap_up  = cc12h_pkg::is_leap(year_up);
  assign day_wrap = cur_i.day >= cc12h_pkg::month_len(cur_i.month, cur_i.leap);

  always_comb begin
    nxt_o = cur_i;
    if (op_i == cc12h_pkg::OP_LOAD) begin
      nxt_o.month     = set_i.month;
      nxt_o.day       = set_i.day;
      nxt_o.year      = set_i.year;
      nxt_o.hour      = set_i.hour;
      nxt_o.minute    = set_i.minute;
      nxt_o.second    = set_i.second;
      nxt_o.pm        = set_i.pm;
      nxt_o.leap      = cc12h_pkg::is_leap(set_i.year);
      nxt_o.noon_seen = (set_i.hour == cc12h_pkg::HOUR_TOP);
    end else if (cur_i.second < cc12h_pkg::SEC_LAST) begin
      nxt_o.second = cur_i.second + 6'd1;
    end else begin
      nxt_o.second = 6'd0;
      if (cur_i.minute < cc12h_pkg::MIN_LAST) begin
        nxt_o.minute = cur_i.minute + 6'd1;
      end else begin
        nxt_o.minute = 6'd0;
        if (cur_i.hour >= cc12h_pkg::HOUR_TOP) begin
          // wrap to one and rearm the noon flip
          nxt_o.hour      = 4'd1;
          nxt_o.noon_seen = 1'b0;
        end else begin
          nxt_o.hour = cur_i.hour + 4'd1;
          if ((cur_i.hour == cc12h_pkg::HOUR_PRE) && !cur_i.noon_seen) begin
            nxt_o.noon_seen = 1'b1;
            nxt_o.pm        = !cur_i.pm;
            // pm to am starts a new day
            if (cur_i.pm) begin
              if (!day_wrap) begin
                nxt_o.day = cur_i.day + 5'd1;
              end else begin
                nxt_o.day = 5'd1;
                if (cur_i.month >= cc12h_pkg::MONTH_LAST) begin
                  nxt_o.month = 4'd1;
                  nxt_o.year  = year_up;
                  nxt_o.leap  = leap_up;
                end else begin
                  nxt_o.month = cur_i.month + 4'd1;
                end
              end
            end
          end
        end
      end
    end
  end

endmodule
